@@ hw/rtl/srrjf_pkg.sv @@
// Package: shared types and constants of the sensor rate/range/jump filter.
`timescale 1ns / 1ps

package srrjf_pkg;

  typedef enum logic [1:0] {
    MODE_RATE     = 2'd0,
    MODE_RANGE    = 2'd1,
    MODE_COMBINED = 2'd2,
    MODE_JUMP     = 2'd3
  } mode_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_RESET   = 3'd5;

  localparam logic [15:0] RATE_LIMIT_RST  = 16'd200;
  localparam logic [15:0] UPPER_LIMIT_RST = 16'd10500;
  localparam logic [15:0] JUMP_LIMIT_RST  = 16'd500;
  localparam logic [31:0] GAP_LIMIT_RST   = 32'd960;

  typedef struct packed {
    mode_e       filter_mode;
    logic [15:0] rate_limit;
    logic [15:0] upper_limit;
    logic [15:0] jump_limit;
    logic [31:0] gap_limit;
    logic        gap_reset_enable;
  } cfg_t;

  typedef struct packed {
    logic fault;
    logic anomaly;
    logic ref_upd;
    logic jump_valid;
  } res_flags_t;

endpackage

@@ hw/rtl/sensor_rate_range_jump_filter_core.sv @@
// Top level: sensor fault filter with input register, reference state and result register.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------------
//   in      | request   | in_valid_i / in_ready_o   | temperature, timestamp, sample_valid
//   out     | result    | out_valid_o / out_ready_i | fault_flag, sample_anomaly,
//           |           |                           | reference_updated, jump_value, jump_valid
//   cfg     | write     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request per cycle sustained while the output does not stall.
// The evaluation sits between the input register and the result register and
// updates the reference in the same cycle the result register loads.
// An output stall holds the result; one more request is taken into the input register.
// Reset clears the reference and loads the configuration defaults.
`timescale 1ns / 1ps

module sensor_rate_range_jump_filter_core
  import srrjf_pkg::*;
#(
  parameter int unsigned TEMP_WIDTH = 16,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [TEMP_WIDTH-1:0] temperature_i,
  input  logic [TIME_WIDTH-1:0]        timestamp_i,
  input  logic                         sample_valid_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         fault_flag_o,
  output logic                         sample_anomaly_o,
  output logic                         reference_updated_o,
  output logic signed [TEMP_WIDTH:0]   jump_value_o,
  output logic                         jump_valid_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i
);

  cfg_t cfg;

  logic                         s1_valid_q;
  logic signed [TEMP_WIDTH-1:0] s1_temp_q;
  logic [TIME_WIDTH-1:0]        s1_time_q;
  logic                         s1_sv_q;
  logic                         s1_adv;
  logic                         s1_fire;
  logic                         in_fire;

  logic                         has_ref_q;
  logic signed [TEMP_WIDTH-1:0] ref_temp_q;
  logic [TIME_WIDTH-1:0]        ref_time_q;

  res_flags_t                   flags;
  logic signed [TEMP_WIDTH:0]   jump;

  logic                         out_valid_q;
  res_flags_t                   out_flags_q;
  logic signed [TEMP_WIDTH:0]   out_jump_q;

  srrjf_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  srrjf_eval #(
    .TEMP_WIDTH (TEMP_WIDTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_eval (
    .cfg_i          (cfg),
    .temp_i         (s1_temp_q),
    .time_i         (s1_time_q),
    .sample_valid_i (s1_sv_q),
    .has_ref_i      (has_ref_q),
    .ref_temp_i     (ref_temp_q),
    .ref_time_i     (ref_time_q),
    .flags_o        (flags),
    .jump_o         (jump)
  );

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      has_ref_q   <= 1'b0;
      ref_temp_q  <= '0;
      ref_time_q  <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_fire && flags.ref_upd) begin
        has_ref_q  <= 1'b1;
        ref_temp_q <= s1_temp_q;
        ref_time_q <= s1_time_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_temp_q <= temperature_i;
      s1_time_q <= timestamp_i;
      s1_sv_q   <= sample_valid_i;
    end
    if (s1_fire) begin
      out_flags_q <= flags;
      out_jump_q  <= jump;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign fault_flag_o        = out_flags_q.fault;
  assign sample_anomaly_o    = out_flags_q.anomaly;
  assign reference_updated_o = out_flags_q.ref_upd;
  assign jump_value_o        = out_jump_q;
  assign jump_valid_o        = out_flags_q.jump_valid;

  a_jump_implies_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && jump_valid_o |-> reference_updated_o && !sample_anomaly_o)
    else $error("jump reported without reference update");

  a_jump_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !jump_valid_o |-> jump_value_o == '0)
    else $error("jump value nonzero while not valid");

  a_anomaly_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(sample_anomaly_o && reference_updated_o))
    else $error("anomaly and reference update together");

  a_ref_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    has_ref_q |=> has_ref_q)
    else $error("reference lost");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without output backpressure");

endmodule

@@ hw/rtl/srrjf_cfg_regs.sv @@
// Configuration register file of the filter.
`timescale 1ns / 1ps

module srrjf_cfg_regs
  import srrjf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_mode      <= MODE_RATE;
      cfg_q.rate_limit       <= RATE_LIMIT_RST;
      cfg_q.upper_limit      <= UPPER_LIMIT_RST;
      cfg_q.jump_limit       <= JUMP_LIMIT_RST;
      cfg_q.gap_limit        <= GAP_LIMIT_RST;
      cfg_q.gap_reset_enable <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FILTER_MODE: cfg_q.filter_mode      <= mode_e'(cfg_data_i[1:0]);
        REG_RATE_LIMIT:  cfg_q.rate_limit       <= cfg_data_i[15:0];
        REG_UPPER_LIMIT: cfg_q.upper_limit      <= cfg_data_i[15:0];
        REG_JUMP_LIMIT:  cfg_q.jump_limit       <= cfg_data_i[15:0];
        REG_GAP_LIMIT:   cfg_q.gap_limit        <= cfg_data_i[31:0];
        REG_GAP_RESET:   cfg_q.gap_reset_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/srrjf_eval.sv @@
// Single-pass evaluation of one sample against the stored reference.
`timescale 1ns / 1ps

module srrjf_eval
  import srrjf_pkg::*;
#(
  parameter int unsigned TEMP_WIDTH = 16,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  cfg_t                         cfg_i,
  input  logic signed [TEMP_WIDTH-1:0] temp_i,
  input  logic [TIME_WIDTH-1:0]        time_i,
  input  logic                         sample_valid_i,
  input  logic                         has_ref_i,
  input  logic signed [TEMP_WIDTH-1:0] ref_temp_i,
  input  logic [TIME_WIDTH-1:0]        ref_time_i,
  output res_flags_t                   flags_o,
  output logic signed [TEMP_WIDTH:0]   jump_o
);

  localparam int unsigned JW = TEMP_WIDTH + 1;
  localparam int unsigned LW = JW + 4;
  localparam int unsigned CW = (TEMP_WIDTH > 16) ? TEMP_WIDTH : 16;
  localparam int unsigned KW = (JW > 16) ? JW : 16;
  localparam int unsigned DW = (TIME_WIDTH > LW) ? TIME_WIDTH : LW;
  localparam int unsigned GW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
  localparam int unsigned PW = LW + 16;

  logic signed [15:0]    upper_s;
  logic signed [CW-1:0]  temp_c;
  logic signed [CW-1:0]  upper_c;
  logic                  over_upper;
  logic signed [JW-1:0]  jump;
  logic [JW-1:0]         mag;
  logic [LW-1:0]         lhs;
  logic [TIME_WIDTH-1:0] dt;
  logic [DW-1:0]         dt_ext;
  logic [PW-1:0]         prod;
  logic                  rate_flag;
  logic                  jump_flag;
  logic                  gap_long;
  logic                  time_back;

  assign upper_s    = cfg_i.upper_limit;
  assign temp_c     = CW'(temp_i);
  assign upper_c    = CW'(upper_s);
  assign over_upper = ((cfg_i.filter_mode == MODE_RANGE) ||
                       (cfg_i.filter_mode == MODE_COMBINED)) && (temp_c > upper_c);

  assign jump = JW'(temp_i) - JW'(ref_temp_i);
  assign mag  = jump[JW-1] ? JW'(-jump) : JW'(jump);
  assign lhs  = {mag, 4'b0000};

  assign time_back = (time_i <= ref_time_i);
  assign dt        = time_i - ref_time_i;
  assign dt_ext    = DW'(dt);
  assign gap_long  = GW'(dt) > GW'(cfg_i.gap_limit);

  // dt is at most lhs whenever the product matters, so its low LW bits suffice
  assign prod = PW'(cfg_i.rate_limit) * PW'(dt_ext[LW-1:0]);

  always_comb begin
    if (cfg_i.rate_limit == '0) begin
      rate_flag = (lhs != '0);
    end else if (dt_ext > DW'(lhs)) begin
      rate_flag = 1'b0;
    end else begin
      rate_flag = PW'(lhs) > prod;
    end
  end

  assign jump_flag = KW'(mag) > KW'(cfg_i.jump_limit);

  always_comb begin
    flags_o = '0;
    jump_o  = '0;
    if (!sample_valid_i) begin
      flags_o.anomaly = 1'b1;
    end else if (!has_ref_i) begin
      flags_o.fault   = over_upper;
      flags_o.ref_upd = 1'b1;
    end else if (time_back) begin
      flags_o.fault   = over_upper;
      flags_o.anomaly = 1'b1;
    end else begin
      flags_o.ref_upd = 1'b1;
      if (gap_long && cfg_i.gap_reset_enable) begin
        flags_o.fault = over_upper;
      end else begin
        case (cfg_i.filter_mode)
          MODE_RATE:     flags_o.fault = rate_flag;
          MODE_RANGE:    flags_o.fault = over_upper;
          MODE_COMBINED: flags_o.fault = over_upper || rate_flag;
          MODE_JUMP:     flags_o.fault = jump_flag;
        endcase
        flags_o.jump_valid = 1'b1;
        jump_o             = jump;
      end
    end
  end

endmodule

@@ sim/tb.sv @@
// Testbench: sensor fault filter verdicts checked against a cycle-free prediction.
`timescale 1ns / 1ps

module tb;
  import srrjf_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef struct {
    res_flags_t         flags;
    logic signed [16:0] jump;
  } verdict_t;

  logic                      clk          = 1'b0;
  logic                      rst_n        = 1'b0;
  logic                      in_valid     = 1'b0;
  logic                      in_ready;
  logic signed [15:0]        temperature  = '0;
  logic [31:0]               timestamp    = '0;
  logic                      sample_valid = 1'b0;
  logic                      out_valid;
  logic                      out_ready    = 1'b0;
  logic                      fault_flag;
  logic                      sample_anomaly;
  logic                      reference_updated;
  logic signed [16:0]        jump_value;
  logic                      jump_valid;
  logic                      cfg_valid    = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index    = '0;
  logic [CFG_DATA_W-1:0]     cfg_data     = '0;

  // predicted filter state
  cfg_t                      shadow_cfg;
  logic signed [15:0]        ref_temp;
  logic [31:0]               ref_time;
  bit                        has_ref;

  verdict_t                  expected_verdicts[$];
  verdict_t                  oldest;
  int                        mismatches   = 0;
  int                        quiet_cycles = 0;
  int                        send_idle_pct  = 0;
  int                        recv_stall_pct = 0;
  logic signed [15:0]        last_temp    = '0;
  logic [31:0]               now_ts       = '0;

  sensor_rate_range_jump_filter_core dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .temperature_i      (temperature),
    .timestamp_i        (timestamp),
    .sample_valid_i     (sample_valid),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .fault_flag_o       (fault_flag),
    .sample_anomaly_o   (sample_anomaly),
    .reference_updated_o(reference_updated),
    .jump_value_o       (jump_value),
    .jump_valid_o       (jump_valid),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [31:0] data);
    case (idx)
      REG_FILTER_MODE: shadow_cfg.filter_mode      = mode_e'(data[1:0]);
      REG_RATE_LIMIT:  shadow_cfg.rate_limit       = data[15:0];
      REG_UPPER_LIMIT: shadow_cfg.upper_limit      = data[15:0];
      REG_JUMP_LIMIT:  shadow_cfg.jump_limit       = data[15:0];
      REG_GAP_LIMIT:   shadow_cfg.gap_limit        = data;
      REG_GAP_RESET:   shadow_cfg.gap_reset_enable = data[0];
      default: ;
    endcase
  endfunction

  // Verdict for one request; advances the reference like the filter does.
  function automatic verdict_t judge_sample(input logic signed [15:0] temp,
                                            input logic [31:0] ts,
                                            input logic present);
    verdict_t           v;
    logic               range_hit;
    logic               rate_hit;
    logic [31:0]        dt;
    logic signed [16:0] jump;
    logic [16:0]        mag;
    longint unsigned    scaled;
    longint unsigned    budget;
    v.flags = '0;
    v.jump  = '0;
    if (!present) begin
      v.flags.anomaly = 1'b1;
      return v;
    end
    range_hit = (shadow_cfg.filter_mode == MODE_RANGE ||
                 shadow_cfg.filter_mode == MODE_COMBINED) &&
                (temp > $signed(shadow_cfg.upper_limit));
    if (!has_ref) begin
      has_ref         = 1'b1;
      ref_temp        = temp;
      ref_time        = ts;
      v.flags.fault   = range_hit;
      v.flags.ref_upd = 1'b1;
    end else if (ts <= ref_time) begin
      v.flags.fault   = range_hit;
      v.flags.anomaly = 1'b1;
    end else begin
      dt = ts - ref_time;
      if (dt > shadow_cfg.gap_limit && shadow_cfg.gap_reset_enable) begin
        v.flags.fault = range_hit;
      end else begin
        jump     = $signed({temp[15], temp}) - $signed({ref_temp[15], ref_temp});
        mag      = jump[16] ? -jump : jump;
        scaled   = longint'(mag) * 16;
        budget   = longint'(shadow_cfg.rate_limit) * longint'(dt);
        rate_hit = scaled > budget;
        case (shadow_cfg.filter_mode)
          MODE_RATE:     v.flags.fault = rate_hit;
          MODE_RANGE:    v.flags.fault = range_hit;
          MODE_COMBINED: v.flags.fault = range_hit || rate_hit;
          default:       v.flags.fault = mag > shadow_cfg.jump_limit;
        endcase
        v.jump             = jump;
        v.flags.jump_valid = 1'b1;
      end
      ref_temp        = temp;
      ref_time        = ts;
      v.flags.ref_upd = 1'b1;
    end
    return v;
  endfunction

  function automatic logic signed [15:0] clamp_temp(input int t);
    if (t > 32767) return 16'sh7FFF;
    if (t < -32768) return 16'sh8000;
    return t[15:0];
  endfunction

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0s at %0t: expected f%0b a%0b u%0b j%0d jv%0b, got f%0b a%0b u%0b j%0d jv%0b",
               what, $realtime, oldest.flags.fault, oldest.flags.anomaly,
               oldest.flags.ref_upd, oldest.jump, oldest.flags.jump_valid, fault_flag,
               sample_anomaly, reference_updated, jump_value, jump_valid);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        oldest.flags = '0;
        oldest.jump  = '0;
        report_mismatch("unexpected result");
      end else begin
        oldest = expected_verdicts.pop_front();
        if (fault_flag !== oldest.flags.fault || sample_anomaly !== oldest.flags.anomaly ||
            reference_updated !== oldest.flags.ref_upd || jump_value !== oldest.jump ||
            jump_valid !== oldest.flags.jump_valid)
          report_mismatch("verdict");
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input logic signed [15:0] temp, input logic [31:0] ts,
                             input logic present);
    int idle_cycles;
    idle_cycles = 0;
    while ($urandom_range(99) < send_idle_pct && idle_cycles < 40) idle_cycles++;
    if (idle_cycles > 0) begin
      in_valid <= 1'b0;
      repeat (idle_cycles) @(posedge clk);
    end
    in_valid     <= 1'b1;
    temperature  <= temp;
    timestamp    <= ts;
    sample_valid <= present;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_verdicts.push_back(judge_sample(temp, ts, present));
  endtask

  task automatic send_after(input logic signed [15:0] temp, input logic [31:0] step);
    now_ts    = now_ts + step;
    last_temp = temp;
    send_sample(temp, now_ts, 1'b1);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_write(idx, data);
  endtask

  task automatic program_filter(input mode_e mode, input logic [15:0] rate,
                                input logic [15:0] upper, input logic [15:0] jlim,
                                input logic [31:0] gap, input logic gap_en);
    drain_results();
    write_reg(REG_FILTER_MODE, 32'(mode));
    write_reg(REG_RATE_LIMIT, 32'(rate));
    write_reg(REG_UPPER_LIMIT, {{16{upper[15]}}, upper});
    write_reg(REG_JUMP_LIMIT, 32'(jlim));
    write_reg(REG_GAP_LIMIT, gap);
    write_reg(REG_GAP_RESET, 32'(gap_en));
    cfg_valid <= 1'b0;
  endtask

  // Defaults out of reset; a missing sample is flagged, the first valid sample only seeds and mode 0 ignores range.
  task automatic test_reset_defaults();
    send_sample(16'sd1234, 32'hA5A5_5A5A, 1'b0);
    now_ts = 32'd1000;
    send_after(16'sd11000, 0);
    send_after(16'sd11200, 16);
    send_after(16'sd11401, 16);
    send_after(16'sd0, 961);
    send_after(16'sd500, 960);
  endtask

  task automatic test_range_rule();
    program_filter(MODE_RANGE, RATE_LIMIT_RST, UPPER_LIMIT_RST, JUMP_LIMIT_RST,
                   GAP_LIMIT_RST, 1'b1);
    send_after(16'sd10500, 1);
    send_after(16'sd10501, 1);
    send_after(16'sd20000, 0);
    send_sample(16'sd20000, now_ts - 5, 1'b1);
    program_filter(MODE_JUMP, RATE_LIMIT_RST, 16'h8000, JUMP_LIMIT_RST, GAP_LIMIT_RST, 1'b1);
    send_after(16'sd10700, 1);
  endtask

  task automatic test_rate_rule();
    program_filter(MODE_RATE, 16'd0, 16'h7FFF, JUMP_LIMIT_RST, GAP_LIMIT_RST, 1'b1);
    send_after(last_temp, 1);
    send_after(last_temp + 16'sd1, 100);
    program_filter(MODE_COMBINED, 16'hFFFF, 16'h7FFF, JUMP_LIMIT_RST, GAP_LIMIT_RST, 1'b1);
    send_after(16'sh8000, 1);
  endtask

  task automatic test_jump_rule();
    program_filter(MODE_JUMP, RATE_LIMIT_RST, UPPER_LIMIT_RST, 16'hFFFF, GAP_LIMIT_RST, 1'b1);
    send_after(16'sh8000, 1);
    send_after(16'sh7FFF, 1);
    send_after(16'sh8000, 1);
    program_filter(MODE_JUMP, RATE_LIMIT_RST, UPPER_LIMIT_RST, 16'd0, GAP_LIMIT_RST, 1'b1);
    send_after(16'sh8000, 1);
    send_after(16'sh8001, 1);
  endtask

  task automatic test_long_gap();
    program_filter(MODE_COMBINED, RATE_LIMIT_RST, 16'd0, JUMP_LIMIT_RST, 32'd100, 1'b1);
    send_after(16'sd50, 100);
    send_after(16'sd60, 101);
    program_filter(MODE_COMBINED, RATE_LIMIT_RST, 16'd0, JUMP_LIMIT_RST, 32'd100, 1'b0);
    send_after(16'sd70, 101);
    program_filter(MODE_COMBINED, RATE_LIMIT_RST, 16'd0, JUMP_LIMIT_RST, 32'd0, 1'b1);
    send_after(-16'sd10, 1);
  endtask

  task automatic pick_random_setting();
    mode_e       mode;
    logic [15:0] rate;
    logic [15:0] upper;
    logic [15:0] jlim;
    logic [31:0] gap;
    mode = mode_e'($urandom_range(3));
    case ($urandom_range(5))
      0:       rate = 16'd0;
      1:       rate = 16'hFFFF;
      default: rate = 16'($urandom_range(1, 400));
    endcase
    case ($urandom_range(7))
      0:       upper = 16'h8000;
      1:       upper = 16'h7FFF;
      default: upper = clamp_temp(int'(last_temp) + $urandom_range(600) - 300);
    endcase
    case ($urandom_range(5))
      0:       jlim = 16'd0;
      1:       jlim = 16'hFFFF;
      default: jlim = 16'($urandom_range(1500));
    endcase
    case ($urandom_range(7))
      0:       gap = 32'd0;
      1:       gap = 32'hFFFF_FFFF;
      default: gap = $urandom_range(16, 400);
    endcase
    program_filter(mode, rate, upper, jlim, gap, 1'($urandom_range(1)));
  endtask

  // Mostly a drifting sensor trace; some missing, backward, wild and gap samples.
  task automatic send_random_samples(input int count);
    int          pick;
    int          step;
    logic signed [15:0] temp;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(63) == 0) drain_results();
      pick = $urandom_range(99);
      if (pick < 8) temp = 16'($urandom);
      else if (pick < 11) temp = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      else temp = clamp_temp(int'(last_temp) + $urandom_range(1200) - 600);
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_sample(temp, $urandom, 1'b0);
      end else if (pick < 16) begin
        last_temp = temp;
        send_sample(temp, now_ts - $urandom_range(now_ts < 50 ? now_ts : 50), 1'b1);
      end else begin
        if (pick < 26 && shadow_cfg.gap_limit <= 4096)
          step = shadow_cfg.gap_limit == 0 ? $urandom_range(1, 2)
                                           : int'(shadow_cfg.gap_limit) - 1 +
                                             $urandom_range(2);
        else
          step = $urandom_range(64);
        send_after(temp, step);
      end
    end
  endtask

  task automatic test_random_traffic();
    int idle_set[4][2] = '{'{0, 0}, '{64, 0}, '{0, 64}, '{24, 24}};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_set[p][0];
      recv_stall_pct = idle_set[p][1];
      for (int k = 0; k < 3; k++) begin
        pick_random_setting();
        send_random_samples(70);
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Timestamps up to the top of the range; huge steps never trip the rate rule.
  task automatic test_time_extremes();
    program_filter(MODE_COMBINED, 16'd1, 16'h7FFF, 16'd0, 32'hFFFF_FFFF, 1'b1);
    send_sample(16'sd100, 32'h8000_0000, 1'b1);
    send_sample(-16'sd100, 32'hFFFF_FFFE, 1'b1);
    send_sample(16'sd0, 32'hFFFF_FFFF, 1'b1);
    send_sample(16'sd5, 32'hFFFF_FFFF, 1'b1);
    send_sample(16'sd5, 32'h0000_0000, 1'b1);
  endtask

  initial begin
    shadow_cfg.filter_mode      = MODE_RATE;
    shadow_cfg.rate_limit       = RATE_LIMIT_RST;
    shadow_cfg.upper_limit      = UPPER_LIMIT_RST;
    shadow_cfg.jump_limit       = JUMP_LIMIT_RST;
    shadow_cfg.gap_limit        = GAP_LIMIT_RST;
    shadow_cfg.gap_reset_enable = 1'b1;
    ref_temp = '0;
    ref_time = '0;
    has_ref  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_reset_defaults();
    test_range_rule();
    test_rate_rule();
    test_jump_rule();
    test_long_gap();
    test_random_traffic();
    test_time_extremes();

    drain_results();
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
